// ----- hdl/lkc_pkg.sv -----
// lkc_pkg: shared constants, opcodes and state encodings for the lru keyed cache
// used by lkc_store and lru_keyed_cache
package lkc_pkg;
  localparam int MaxEntries = 16;
  localparam int KeyBits    = 64;
  localparam int ValueBits  = 32;
  localparam int SlotBits   = $clog2(MaxEntries);
  localparam int CountBits  = $clog2(MaxEntries + 1);
  localparam int CapBits    = 5;
  localparam int OutBits    = 32;

  typedef logic [SlotBits-1:0]  slot_t;
  typedef logic [CountBits-1:0] count_t;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_INSERT = 2'd1,
    OP_ERASE  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT,
    ST_DRAIN_RD,
    ST_DRAIN_OUT,
    ST_OUT
  } state_t;
endpackage

// ----- hdl/lkc_store.sv -----
// lkc_store: value memory, one synchronous write port and one registered read
// depends on lkc_pkg
module lkc_store (
  input  logic                         clk,
  input  logic                         wr_en,
  input  lkc_pkg::slot_t               wr_addr,
  input  logic [lkc_pkg::ValueBits-1:0] wr_data,
  input  logic                         rd_en,
  input  lkc_pkg::slot_t               rd_addr,
  output logic [lkc_pkg::ValueBits-1:0] rd_data
);
  import lkc_pkg::*;

  logic [ValueBits-1:0] mem [MaxEntries];

  // write port and registered read port, read data held between reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ----- hdl/lru_keyed_cache.sv -----
// lru_keyed_cache: fully associative key/value cache with lru replacement
// find/insert/erase: match and memory read in ST_READ, emit in ST_EMIT, result valid in ST_OUT
// a new request is accepted once the result is taken and the cache is back in ST_IDLE
// clear of n > 0 entries gives n results, each read in ST_DRAIN_RD (one value memory read port)
// synchronous reset empties the cache and sets capacity_limit to 16
// depends on lkc_pkg, lkc_store
module lru_keyed_cache (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lkc_pkg::CapBits-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    opcode,
  input  logic [63:0]                   lookup_key,
  input  logic [31:0]                   entry_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          value_valid,
  output logic [31:0]                   value_out,
  output logic [4:0]                    occupancy,
  output logic                          last_result
);
  import lkc_pkg::*;

  state_t state, state_next;

  logic [CapBits-1:0]  capacity_limit;
  logic [KeyBits-1:0]  keys [MaxEntries];
  logic [MaxEntries-1:0] valid;
  slot_t               rank [MaxEntries];
  count_t              count;

  op_t                 op;
  logic [KeyBits-1:0]  key;
  logic [ValueBits-1:0] val;
  count_t              drain_n;
  count_t              drain_r;

  // result register
  logic                res_vv;
  logic [ValueBits-1:0] res_val;
  logic                res_use_mem;
  count_t              res_occ;
  logic                res_last;

  // value memory
  logic                 mem_we;
  slot_t                mem_wa;
  logic [ValueBits-1:0] mem_wd;
  logic                 mem_re;
  slot_t                mem_ra;
  logic [ValueBits-1:0] mem_rd;

  lkc_store u_store (
    .clk(clk), .wr_en(mem_we), .wr_addr(mem_wa), .wr_data(mem_wd),
    .rd_en(mem_re), .rd_addr(mem_ra), .rd_data(mem_rd)
  );

  // capacity clamp, key match, rank searches, free slot
  count_t cap;
  logic   hit;
  slot_t  hit_slot;
  logic   lru_found;
  slot_t  lru_slot;
  logic   free_found;
  slot_t  free_slot;
  slot_t  rank_slot;
  logic   full_evict;

  always_comb begin
    cap = (capacity_limit > CapBits'(MaxEntries)) ? count_t'(MaxEntries)
                                                  : count_t'(capacity_limit);
    hit = 1'b0; hit_slot = '0;
    lru_found = 1'b0; lru_slot = '0;
    free_found = 1'b0; free_slot = '0;
    rank_slot = '0;
    for (int i = MaxEntries - 1; i >= 0; i--) begin
      if (valid[i] && keys[i] == key) begin
        hit = 1'b1; hit_slot = slot_t'(i);
      end
      if (valid[i] && count_t'(rank[i]) == count - count_t'(1)) begin
        lru_found = 1'b1; lru_slot = slot_t'(i);
      end
      if (valid[i] && count_t'(rank[i]) == drain_r) begin
        rank_slot = slot_t'(i);
      end
    end
    full_evict = (count >= cap) && (count != '0) && lru_found;
    for (int i = MaxEntries - 1; i >= 0; i--) begin
      if (!valid[i] || (full_evict && slot_t'(i) == lru_slot)) begin
        free_found = 1'b1; free_slot = slot_t'(i);
      end
    end
  end

  assign cfg_ready = (state == ST_IDLE);
  assign in_ready  = (state == ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_valid) state_next = ST_READ;
      ST_READ: begin
        if (op == OP_CLEAR && count != '0) state_next = ST_DRAIN_RD;
        else state_next = ST_EMIT;
      end
      ST_EMIT:      state_next = ST_OUT;
      ST_DRAIN_RD:  state_next = ST_DRAIN_OUT;
      ST_DRAIN_OUT: if (out_ready) begin
        state_next = (drain_r == drain_n) ? ST_IDLE : ST_DRAIN_RD;
      end
      ST_OUT:       if (out_ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // memory port control: read the slot touched in ST_READ or the drained rank in ST_DRAIN_RD, write on insert
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = val;
    mem_re = (state == ST_READ) || (state == ST_DRAIN_RD);
    mem_ra = rank_slot;
    if (state == ST_READ) begin
      mem_ra = (op == OP_INSERT) ? lru_slot : hit_slot;
      if (op == OP_INSERT && cap != '0) begin
        if (hit) begin
          mem_we = 1'b1; mem_wa = hit_slot;
        end else if (free_found) begin
          mem_we = 1'b1; mem_wa = free_slot;
        end
      end
    end
  end

  // outputs
  assign out_valid   = (state == ST_OUT) || (state == ST_DRAIN_OUT);
  assign value_valid = res_vv;
  assign value_out   = !res_vv ? '0 : (res_use_mem ? OutBits'(mem_rd) : OutBits'(res_val));
  assign occupancy   = 5'(res_occ);
  assign last_result = res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      capacity_limit <= CapBits'(MaxEntries);
      valid <= '0;
      count <= '0;
      drain_r <= '0;
      res_vv <= 1'b0;
      for (int i = 0; i < MaxEntries; i++) rank[i] <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) capacity_limit <= cfg_data;
      if (state == ST_IDLE && in_valid) begin
        op  <= op_t'(opcode);
        key <= KeyBits'(lookup_key);
        val <= ValueBits'(entry_value);
      end
      // state update happens in ST_READ; value read completes next cycle
      if (state == ST_READ) begin
        res_use_mem <= 1'b0;
        res_val <= val;
        res_last <= 1'b1;
        res_vv <= 1'b0;
        res_occ <= count;
        case (op)
          OP_FIND: if (cap != '0 && hit) begin
            res_vv <= 1'b1; res_use_mem <= 1'b1;
            for (int i = 0; i < MaxEntries; i++)
              if (valid[i] && rank[i] < rank[hit_slot]) rank[i] <= rank[i] + slot_t'(1);
            rank[hit_slot] <= '0;
          end
          OP_INSERT: begin
            if (cap == '0) begin
              res_vv <= 1'b1;
            end else if (hit) begin
              for (int i = 0; i < MaxEntries; i++)
                if (valid[i] && rank[i] < rank[hit_slot]) rank[i] <= rank[i] + slot_t'(1);
              rank[hit_slot] <= '0;
            end else begin
              // evicted lru has top rank, so all other ranks simply shift up
              for (int i = 0; i < MaxEntries; i++)
                if (valid[i]) rank[i] <= rank[i] + slot_t'(1);
              if (full_evict) begin
                res_vv <= 1'b1; res_use_mem <= 1'b1;
                valid[lru_slot] <= 1'b0;
              end
              if (free_found) begin
                valid[free_slot] <= 1'b1;
                rank[free_slot] <= '0;
                keys[free_slot] <= key;
              end
              res_occ <= count - count_t'(full_evict) + count_t'(free_found);
              count   <= count - count_t'(full_evict) + count_t'(free_found);
            end
          end
          OP_ERASE: if (hit) begin
            res_vv <= 1'b1; res_use_mem <= 1'b1;
            valid[hit_slot] <= 1'b0;
            for (int i = 0; i < MaxEntries; i++)
              if (valid[i] && rank[i] > rank[hit_slot]) rank[i] <= rank[i] - slot_t'(1);
            res_occ <= count - count_t'(1);
            count   <= count - count_t'(1);
          end
          OP_CLEAR: begin
            res_occ <= '0;
            drain_n <= count;
            drain_r <= '0;
          end
          default: ;
        endcase
      end
      // clear drain: look up slot of current rank, read its value
      if (state == ST_DRAIN_RD) begin
        res_vv <= 1'b1;
        res_use_mem <= 1'b1;
        res_occ <= '0;
        res_last <= (drain_r + count_t'(1) == drain_n);
        drain_r <= drain_r + count_t'(1);
      end
      if (state == ST_DRAIN_OUT && out_ready && drain_r == drain_n) begin
        valid <= '0;
        count <= '0;
        for (int i = 0; i < MaxEntries; i++) rank[i] <= '0;
      end
    end
  end

  // value_out must stay steady while a result waits in ST_OUT
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !out_ready) |=> $stable(value_out))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    count <= count_t'(MaxEntries))
    else $error("occupancy overflow");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ($countones(valid) == int'(count)))
    else $error("valid bits disagree with count");
endmodule
